FILE: sv/rbc_pkg.sv
// package for the rgba blend mode compositor: widths, codes, pipeline control
// struct and the exact divide-by-255 helper; no dependencies
package rbc_pkg;

    localparam int NSTG = 7;              // register stages from input to output
    localparam int CH_W = 8;              // width of one pixel channel
    localparam int PROD_W = 2 * CH_W;     // product of two channels
    localparam int IN_W = 8 * CH_W;       // source and destination pixel
    localparam int OUT_W = 4 * CH_W;      // composited pixel
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CH_W-1:0] FULL = 8'hff;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP         = 2'd2;

    // blend modes, codes above MODE_MULT pass the destination through
    localparam logic [2:0] MODE_NORMAL  = 3'd0;
    localparam logic [2:0] MODE_ADD     = 3'd1;
    localparam logic [2:0] MODE_SUB     = 3'd2;
    localparam logic [2:0] MODE_INV_SUB = 3'd3;
    localparam logic [2:0] MODE_MULT    = 3'd4;

    typedef struct packed {
        logic [NSTG-1:0] load;            // per-stage register load
    } t_pipe_ctl;

    // floor(x / 255), exact for x up to 255*255
    function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] t;
        t = {1'b0, x} + (PROD_W+1)'(1) + (PROD_W+1)'(x >> CH_W);
        return t[PROD_W-1:CH_W];
    endfunction

endpackage

FILE: sv/rbc_alpha_unit.sv
// effective and inverse alpha, stages 0 and 1 of the pipeline
// depends on rbc_pkg
module rbc_alpha_unit (
    input  logic                    i_clk,
    input  rbc_pkg::t_pipe_ctl      i_ctl,
    input  logic [rbc_pkg::CH_W-1:0] i_src_alpha,
    input  logic [rbc_pkg::CH_W-1:0] i_global_alpha,
    output logic [rbc_pkg::CH_W-1:0] o_a,
    output logic [rbc_pkg::CH_W-1:0] o_ia
);
    import rbc_pkg::*;

    logic [PROD_W-1:0] r_pa;
    logic [CH_W-1:0]   r_a;
    logic [CH_W-1:0]   r_ia;
    logic [CH_W-1:0]   n_a;

    assign n_a = div255(r_pa);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_pa <= PROD_W'(i_src_alpha) * PROD_W'(i_global_alpha);
        end
        if (i_ctl.load[1]) begin
            r_a  <= n_a;
            r_ia <= FULL - n_a;
        end
    end

    assign o_a  = r_a;
    assign o_ia = r_ia;

endmodule

FILE: sv/rbc_channel_unit.sv
// one colour channel of the blend, stages 2 to 6
// depends on rbc_pkg
module rbc_channel_unit (
    input  logic                    i_clk,
    input  rbc_pkg::t_pipe_ctl      i_ctl,
    input  logic [2:0]              i_mode,
    input  logic [rbc_pkg::CH_W-1:0] i_a,
    input  logic [rbc_pkg::CH_W-1:0] i_ia,
    input  logic [rbc_pkg::CH_W-1:0] i_src,
    input  logic [rbc_pkg::CH_W-1:0] i_dst,
    output logic [rbc_pkg::CH_W-1:0] o_out
);
    import rbc_pkg::*;

    // stage 2
    logic [PROD_W-1:0] r_sa;
    logic [PROD_W-1:0] r_dia;
    logic [CH_W-1:0]   r_d2;
    // stage 3
    logic [CH_W-1:0]   r_norm;
    logic [CH_W-1:0]   r_q1;
    logic [CH_W-1:0]   r_r1;
    logic [CH_W-1:0]   r_d3;
    // stage 4
    logic [PROD_W-1:0] r_qd;
    logic [PROD_W-1:0] r_rd;
    logic [CH_W-1:0]   r_lin4;
    // stage 5
    logic [PROD_W-1:0] r_m;
    logic [CH_W-1:0]   r_lin5;
    // stage 6
    logic [CH_W-1:0]   r_out;

    logic [CH_W-1:0]   n_q1;
    logic [PROD_W-1:0] n_rem;
    logic [CH_W:0]     n_sum;
    logic [CH_W-1:0]   n_lin;

    assign n_q1  = div255(r_sa);
    // s*a = 255*q1 + r1
    assign n_rem = r_sa - {n_q1, {CH_W{1'b0}}} + {{CH_W{1'b0}}, n_q1};
    assign n_sum = {1'b0, r_d3} + {1'b0, r_q1};

    // modes that need no second product, pass-through takes the destination; multiply is picked later
    always_comb begin
        if (i_mode == MODE_NORMAL) begin
            n_lin = r_norm;
        end else if (i_mode == MODE_ADD) begin
            n_lin = n_sum[CH_W] ? FULL : n_sum[CH_W-1:0];
        end else if (i_mode == MODE_SUB) begin
            n_lin = (r_d3 > r_q1) ? (r_d3 - r_q1) : '0;
        end else if (i_mode == MODE_INV_SUB) begin
            n_lin = (r_q1 > r_d3) ? (r_q1 - r_d3) : '0;
        end else begin
            n_lin = r_d3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r_sa  <= PROD_W'(i_src) * PROD_W'(i_a);
            r_dia <= PROD_W'(i_dst) * PROD_W'(i_ia);
            r_d2  <= i_dst;
        end
        if (i_ctl.load[3]) begin
            r_norm <= div255(PROD_W'(r_sa + r_dia));
            r_q1   <= n_q1;
            r_r1   <= n_rem[CH_W-1:0];
            r_d3   <= r_d2;
        end
        if (i_ctl.load[4]) begin
            // s*a*d/255 = q1*d + r1*d/255
            r_qd   <= PROD_W'(r_q1) * PROD_W'(r_d3);
            r_rd   <= PROD_W'(r_r1) * PROD_W'(r_d3);
            r_lin4 <= n_lin;
        end
        if (i_ctl.load[5]) begin
            r_m    <= r_qd + {{CH_W{1'b0}}, div255(r_rd)};
            r_lin5 <= r_lin4;
        end
        if (i_ctl.load[6]) begin
            r_out <= (i_mode == MODE_MULT) ? div255(r_m) : r_lin5;
        end
    end

    assign o_out = r_out;

endmodule

FILE: sv/rbc_cover_unit.sv
// output alpha 255 - ia*(255-da)/255, stages 2 to 6
// depends on rbc_pkg
module rbc_cover_unit (
    input  logic                    i_clk,
    input  rbc_pkg::t_pipe_ctl      i_ctl,
    input  logic [2:0]              i_mode,
    input  logic [rbc_pkg::CH_W-1:0] i_ia,
    input  logic [rbc_pkg::CH_W-1:0] i_dst_alpha,
    output logic [rbc_pkg::CH_W-1:0] o_alpha
);
    import rbc_pkg::*;

    logic [PROD_W-1:0] r_ip;
    logic [CH_W-1:0]   r_da2;
    logic [CH_W-1:0]   r_cov [3:NSTG-1];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r_ip  <= PROD_W'(i_ia) * PROD_W'(FULL - i_dst_alpha);
            r_da2 <= i_dst_alpha;
        end
        if (i_ctl.load[3]) begin
            // unused modes keep the destination alpha
            r_cov[3] <= (i_mode > MODE_MULT) ? r_da2 : (FULL - div255(r_ip));
        end
        for (int k = 4; k < NSTG; k++) begin
            if (i_ctl.load[k]) begin
                r_cov[k] <= r_cov[k-1];
            end
        end
    end

    assign o_alpha = r_cov[NSTG-1];

endmodule

FILE: sv/rgba_blend_mode_compositor.sv
// top level of the rgba blend mode compositor: config registers, pipeline valid
// and stall control, pixel staging; depends on rbc_pkg and the three rbc units
//
//  port group     dir  beat contents
//  s_axis_*       in   source and destination pixel pair, 64-bit tdata
//  m_axis_*       out  composited pixel, 32-bit tdata
//  i_cfg_*        in   register write: 0 global alpha, 1 blend mode, 2 swap
//
// seven register stages, one pixel per cycle when not stalled
// stage 0 takes the alpha product, 1 scales it, 2 to 6 blend and pick the mode
// every stage has a valid bit and loads when empty or when the next one moves,
// so bubbles close up and a stalled output holds its beat
// reset clears the valid bits and sets global alpha 255, normal mode, no swap
module rgba_blend_mode_compositor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // src_c1, src_c2, src_c3, src_alpha, dst_c1, dst_c2, dst_c3, dst_alpha
    input  logic [rbc_pkg::IN_W-1:0]        s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_c1, out_c2, out_c3, out_alpha
    output logic [rbc_pkg::OUT_W-1:0]       m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [rbc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rbc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import rbc_pkg::*;

    logic [CH_W-1:0] r_global_alpha;
    logic [2:0]      r_blend_mode;
    logic            r_swap;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] n_adv;
    t_pipe_ctl       w_ctl;

    logic [CH_W-1:0] r_src0 [3];
    logic [CH_W-1:0] r_dst0 [4];
    logic [CH_W-1:0] r_src1 [3];
    logic [CH_W-1:0] r_dst1 [4];

    logic [CH_W-1:0] w_a;
    logic [CH_W-1:0] w_ia;
    logic [CH_W-1:0] w_out [3];
    logic [CH_W-1:0] w_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_global_alpha <= FULL;
            r_blend_mode   <= MODE_NORMAL;
            r_swap         <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_GLOBAL_ALPHA) begin
                r_global_alpha <= i_cfg_data;
            end else if (i_cfg_idx == CFG_BLEND_MODE) begin
                r_blend_mode <= i_cfg_data[2:0];
            end else if (i_cfg_idx == CFG_SWAP) begin
                r_swap <= i_cfg_data[0];
            end
        end
    end

    // a stage moves when it is empty or its successor moves
    always_comb begin
        n_adv[NSTG-1] = !r_v[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            n_adv[k] = !r_v[k] || n_adv[k+1];
        end
    end

    assign w_ctl.load    = n_adv;
    assign s_axis_tready = n_adv[0];
    assign m_axis_tvalid = r_v[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (n_adv[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (n_adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv[0]) begin
            r_src0[0] <= r_swap ? s_axis_tdata[23:16] : s_axis_tdata[7:0];
            r_src0[1] <= s_axis_tdata[15:8];
            r_src0[2] <= r_swap ? s_axis_tdata[7:0] : s_axis_tdata[23:16];
            r_dst0[0] <= s_axis_tdata[39:32];
            r_dst0[1] <= s_axis_tdata[47:40];
            r_dst0[2] <= s_axis_tdata[55:48];
            r_dst0[3] <= s_axis_tdata[63:56];
        end
        if (n_adv[1]) begin
            r_src1 <= r_src0;
            r_dst1 <= r_dst0;
        end
    end

    rbc_alpha_unit u_alpha (
        .i_clk          (i_clk),
        .i_ctl          (w_ctl),
        .i_src_alpha    (s_axis_tdata[31:24]),
        .i_global_alpha (r_global_alpha),
        .o_a            (w_a),
        .o_ia           (w_ia)
    );

    for (genvar c = 0; c < 3; c++) begin : g_chan
        rbc_channel_unit u_chan (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_mode (r_blend_mode),
            .i_a    (w_a),
            .i_ia   (w_ia),
            .i_src  (r_src1[c]),
            .i_dst  (r_dst1[c]),
            .o_out  (w_out[c])
        );
    end

    rbc_cover_unit u_cover (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_mode      (r_blend_mode),
        .i_ia        (w_ia),
        .i_dst_alpha (r_dst1[3]),
        .o_alpha     (w_alpha)
    );

    assign m_axis_tdata = {w_alpha, w_out[2], w_out[1], w_out[0]};

    // an accepted beat always lands in stage 0
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_v[0])
        else $error("accepted beat missing from stage 0");

    // with the output stage empty the input never stalls
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NSTG-1] |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    // a full pipeline blocked at the output takes nothing
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_v) && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while pipeline full and stalled");

    // a stalled output beat is not overwritten by a moving stage 5
    a_hold_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(r_v[NSTG-1]))
        else $error("output beat lost during stall");

endmodule

FILE: tb/tb_rgba_blend_mode_compositor.sv
// self-checking testbench for rgba_blend_mode_compositor: directed pixel table, then random
// pixel pairs across register settings, checked against a behavioral blend model
// depends on rbc_pkg and the compositor rtl
module tb_rgba_blend_mode_compositor;
    timeunit 1ns;
    timeprecision 1ps;
    import rbc_pkg::*;

    localparam int unsigned FULL_U = FULL;
    localparam int N_PHASES = 14;
    localparam int PHASE_ITEMS = 50;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    // fields from the lowest bit up: src_c1 src_c2 src_c3 src_alpha dst_c1 dst_c2 dst_c3 dst_alpha
    typedef struct packed {
        logic [7:0] dst_alpha;
        logic [7:0] dst_c3;
        logic [7:0] dst_c2;
        logic [7:0] dst_c1;
        logic [7:0] src_alpha;
        logic [7:0] src_c3;
        logic [7:0] src_c2;
        logic [7:0] src_c1;
    } pix_in_t;

    // fields from the lowest bit up: out_c1 out_c2 out_c3 out_alpha
    typedef struct packed {
        logic [7:0] out_alpha;
        logic [7:0] out_c3;
        logic [7:0] out_c2;
        logic [7:0] out_c1;
    } pix_out_t;

    typedef struct packed {
        logic [7:0] ga;
        logic [2:0] mode;
        logic       swp;
    } blend_cfg_t;

    typedef struct {
        blend_cfg_t cfg;
        pix_in_t    px;
        bit         known;
        pix_out_t   want;
    } pix_row_t;

    localparam blend_cfg_t CFG_RESET = '{ga: 8'd255, mode: MODE_NORMAL, swp: 1'b0};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    rgba_blend_mode_compositor i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    pix_out_t   blended_q[$];
    pix_row_t   pix_table[$];
    blend_cfg_t cfg_now = CFG_RESET;
    int         snd_idle_pct = 0;
    int         rcv_idle_pct = 0;
    bit         hold_req = 1'b0;
    bit         hold_done = 1'b0;
    int         hold_left = 0;
    int         n_sent = 0;
    int         n_recv = 0;
    int         n_cfg = 0;
    int         n_bad = 0;
    int         cycles = 0;
    logic [OUT_W-1:0] got_px;
    logic [OUT_W-1:0] want_px;
    bit         beat_bad;
    string      fld_name[4] = '{"out_c1", "out_c2", "out_c3", "out_alpha"};

    // ---------------------------------------------------------------- blend model

    function automatic logic [7:0] mix_channel(logic [2:0] mode, int unsigned s, int unsigned d,
                                               int unsigned a, int unsigned ia);
        int unsigned sa;
        sa = s * a / FULL_U;
        unique case (mode)
            MODE_NORMAL:  return 8'((s * a + d * ia) / FULL_U);
            MODE_ADD:     return (d + sa > FULL_U) ? 8'hff : 8'(d + sa);
            MODE_SUB:     return (d > sa) ? 8'(d - sa) : 8'h00;
            MODE_INV_SUB: return (sa > d) ? 8'(sa - d) : 8'h00;
            default:      return 8'((s * a * d / FULL_U) / FULL_U);
        endcase
    endfunction

    function automatic pix_out_t composite(pix_in_t p, blend_cfg_t c);
        pix_out_t    r;
        int unsigned a;
        int unsigned ia;
        int unsigned src_a;
        int unsigned dst_a;
        int unsigned s1;
        int unsigned s3;
        // codes above multiply leave the destination pixel as it is
        if (c.mode > MODE_MULT) begin
            r = '{out_c1: p.dst_c1, out_c2: p.dst_c2, out_c3: p.dst_c3, out_alpha: p.dst_alpha};
            return r;
        end
        src_a = p.src_alpha;
        dst_a = p.dst_alpha;
        a = src_a * int'(c.ga) / FULL_U;
        ia = FULL_U - a;
        s1 = c.swp ? p.src_c3 : p.src_c1;
        s3 = c.swp ? p.src_c1 : p.src_c3;
        r.out_c1 = mix_channel(c.mode, s1, p.dst_c1, a, ia);
        r.out_c2 = mix_channel(c.mode, p.src_c2, p.dst_c2, a, ia);
        r.out_c3 = mix_channel(c.mode, s3, p.dst_c3, a, ia);
        r.out_alpha = 8'(FULL_U - ia * (FULL_U - dst_a) / FULL_U);
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic pix_in_t pin(logic [7:0] s1, logic [7:0] s2, logic [7:0] s3,
                                    logic [7:0] sa, logic [7:0] d1, logic [7:0] d2,
                                    logic [7:0] d3, logic [7:0] da);
        pix_in_t p;
        p = '{src_c1: s1, src_c2: s2, src_c3: s3, src_alpha: sa,
              dst_c1: d1, dst_c2: d2, dst_c3: d3, dst_alpha: da};
        return p;
    endfunction

    function automatic pix_out_t pout(logic [7:0] c1, logic [7:0] c2, logic [7:0] c3,
                                      logic [7:0] ca);
        pix_out_t p;
        p = '{out_c1: c1, out_c2: c2, out_c3: c3, out_alpha: ca};
        return p;
    endfunction

    function automatic blend_cfg_t mkcfg(logic [7:0] ga, logic [2:0] mode, logic swp);
        blend_cfg_t c;
        c = '{ga: ga, mode: mode, swp: swp};
        return c;
    endfunction

    task automatic add_row(blend_cfg_t c, pix_in_t px, bit known, pix_out_t want);
        pix_row_t r;
        r.cfg = c;
        r.px = px;
        r.known = known;
        r.want = want;
        pix_table.push_back(r);
    endtask

    // channel values lean toward the ends of the range
    function automatic logic [7:0] rnd_chan();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0) return 8'h00;
        if (k == 1) return 8'hff;
        return 8'($urandom);
    endfunction

    function automatic pix_in_t rnd_pixel();
        return pin(rnd_chan(), rnd_chan(), rnd_chan(), rnd_chan(),
                   rnd_chan(), rnd_chan(), rnd_chan(), rnd_chan());
    endfunction

    // offer one pixel pair; the expected pixel is queued when the beat is taken
    task automatic send_pixel(pix_in_t px, bit known, pix_out_t want);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        blended_q.push_back(known ? want : composite(px, cfg_now));
        n_sent++;
    endtask

    // stop offering, wait for every pending pixel, then let the pipe run empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (blended_q.size() != 0) @(posedge i_clk);
        repeat (NSTG + 2) @(posedge i_clk);
    endtask

    task automatic load_cfg(blend_cfg_t c);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_GLOBAL_ALPHA;
        i_cfg_data <= c.ga;
        @(posedge i_clk);
        i_cfg_idx <= CFG_BLEND_MODE;
        i_cfg_data <= CFG_DATA_W'(c.mode);
        @(posedge i_clk);
        i_cfg_idx <= CFG_SWAP;
        i_cfg_data <= CFG_DATA_W'(c.swp);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_now = c;
        n_cfg++;
    endtask

    task automatic flag_mismatch();
        n_bad++;
    endtask

    // ---------------------------------------------------------------- receiver and checker

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_px = m_axis_tdata;
            if (blended_q.size() == 0) begin
                flag_mismatch();
                if (n_bad <= 10)
                    $display("unexpected beat %h with nothing pending", got_px);
            end else begin
                want_px = blended_q.pop_front();
                beat_bad = 1'b0;
                for (int k = 0; k < 4; k++) begin
                    if (got_px[8*k +: 8] !== want_px[8*k +: 8]) begin
                        if (!beat_bad) flag_mismatch();
                        beat_bad = 1'b1;
                        if (n_bad <= 10)
                            $display("pixel %0d %s: expected %02h got %02h", n_recv,
                                     fld_name[k], want_px[8*k +: 8], got_px[8*k +: 8]);
                    end
                end
            end
            n_recv++;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels pending", cycles, blended_q.size());
            $display("** rgba_blend_mode_compositor: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        blend_cfg_t c;
        pix_out_t   none;
        none = '0;

        // directed table: reset settings first, then each mode and the corner settings
        add_row(CFG_RESET, pin(8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff), 1,
                pout(8'hff, 8'hff, 8'hff, 8'hff));
        add_row(CFG_RESET, pin(8'h12, 8'h34, 8'h56, 8'hff, 8'h9a, 8'hbc, 8'hde, 8'h00), 1,
                pout(8'h12, 8'h34, 8'h56, 8'hff));
        add_row(CFG_RESET, pin(8'hff, 8'hff, 8'hff, 8'h00, 8'hab, 8'hcd, 8'hef, 8'h40), 1,
                pout(8'hab, 8'hcd, 8'hef, 8'h40));
        add_row(CFG_RESET, pin(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff), 1,
                pout(8'hff, 8'hff, 8'hff, 8'hff));
        add_row(CFG_RESET, pin(8'h80, 8'h40, 8'h20, 8'h80, 8'h10, 8'hc0, 8'h7f, 8'h80), 0, none);
        c = mkcfg(8'd255, MODE_ADD, 1'b0);
        // add saturates at full scale
        add_row(c, pin(8'hff, 8'hff, 8'hff, 8'hff, 8'hc8, 8'h01, 8'hff, 8'h00), 1,
                pout(8'hff, 8'hff, 8'hff, 8'hff));
        add_row(c, pin(8'h00, 8'h00, 8'h00, 8'hff, 8'h11, 8'h22, 8'h33, 8'h44), 1,
                pout(8'h11, 8'h22, 8'h33, 8'hff));
        add_row(c, pin(8'h90, 8'h60, 8'h30, 8'ha0, 8'h80, 8'ha0, 8'hf0, 8'h20), 0, none);
        c = mkcfg(8'd255, MODE_SUB, 1'b0);
        add_row(c, pin(8'hff, 8'hff, 8'hff, 8'hff, 8'h64, 8'h00, 8'hff, 8'h7f), 1,
                pout(8'h00, 8'h00, 8'h00, 8'hff));
        add_row(c, pin(8'h30, 8'h70, 8'hb0, 8'hc0, 8'h90, 8'h20, 8'hff, 8'h00), 0, none);
        c = mkcfg(8'd255, MODE_INV_SUB, 1'b0);
        add_row(c, pin(8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                pout(8'hff, 8'hff, 8'hff, 8'hff));
        add_row(c, pin(8'h00, 8'h00, 8'h00, 8'hff, 8'h01, 8'h80, 8'hff, 8'h00), 1,
                pout(8'h00, 8'h00, 8'h00, 8'hff));
        c = mkcfg(8'd255, MODE_MULT, 1'b0);
        add_row(c, pin(8'hff, 8'hff, 8'hff, 8'hff, 8'h12, 8'h80, 8'hfe, 8'h33), 1,
                pout(8'h12, 8'h80, 8'hfe, 8'hff));
        add_row(c, pin(8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff), 1,
                pout(8'h00, 8'h00, 8'h00, 8'hff));
        add_row(c, pin(8'hc0, 8'h70, 8'hff, 8'h90, 8'h80, 8'hff, 8'h40, 8'h60), 0, none);
        // unused mode codes pass the destination through
        add_row(mkcfg(8'd255, 3'(MODE_MULT + 1), 1'b0),
                pin(8'hff, 8'h00, 8'hff, 8'hff, 8'h21, 8'h43, 8'h65, 8'h87), 1,
                pout(8'h21, 8'h43, 8'h65, 8'h87));
        add_row(mkcfg(8'd255, 3'(MODE_MULT + 2), 1'b1),
                pin(8'h00, 8'hff, 8'h00, 8'h00, 8'hfe, 8'hdc, 8'hba, 8'h98), 1,
                pout(8'hfe, 8'hdc, 8'hba, 8'h98));
        add_row(mkcfg(8'd0, 3'(MODE_MULT + 3), 1'b0),
                pin(8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                pout(8'h00, 8'h00, 8'h00, 8'h00));
        // zero global alpha hides the source entirely
        c = mkcfg(8'd0, MODE_NORMAL, 1'b0);
        add_row(c, pin(8'hff, 8'hff, 8'hff, 8'hff, 8'h5a, 8'ha5, 8'h3c, 8'hc3), 1,
                pout(8'h5a, 8'ha5, 8'h3c, 8'hc3));
        add_row(c, pin(8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                pout(8'h00, 8'h00, 8'h00, 8'h00));
        add_row(mkcfg(8'd1, MODE_NORMAL, 1'b0),
                pin(8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00), 0, none);
        c = mkcfg(8'd255, MODE_NORMAL, 1'b1);
        add_row(c, pin(8'h11, 8'h22, 8'h33, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                pout(8'h33, 8'h22, 8'h11, 8'hff));
        add_row(mkcfg(8'd255, MODE_ADD, 1'b1),
                pin(8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00), 0, none);

        snd_idle_pct = 37;
        rcv_idle_pct = 56;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (pix_table[i]) begin
            if (pix_table[i].cfg != cfg_now) load_cfg(pix_table[i].cfg);
            send_pixel(pix_table[i].px, pix_table[i].known, pix_table[i].want);
        end

        // random phases, each under its own register setting
        for (int p = 0; p < N_PHASES; p++) begin
            case (p % 5)
                0: c.ga = 8'd255;
                1: c.ga = 8'd0;
                2: c.ga = 8'd1;
                3: c.ga = 8'd128;
                default: c.ga = 8'($urandom);
            endcase
            c.mode = 3'(p % 8);
            c.swp = (p % 3 == 1);
            load_cfg(c);
            if (p < 5) begin
                snd_idle_pct = 37;
                rcv_idle_pct = 56;
            end else if (p < 10) begin
                snd_idle_pct = 56;
                rcv_idle_pct = 37;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            // long output stall with the input still pushing
            if (p == 12) hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_pixel(rnd_pixel(), 1'b0, none);
        end

        settle();
        repeat (NSTG) @(posedge i_clk);
        if (blended_q.size() != 0) begin
            n_bad += blended_q.size();
            $display("%0d expected pixels never came out", blended_q.size());
        end
        $display("sent %0d pixel pairs, checked %0d composited pixels over %0d register loads",
                 n_sent, n_recv, n_cfg);
        $display("mode codes 0 to 7, global alpha 0/1/128/255/random, swap on and off, %0d bad",
                 n_bad);
        if (n_bad == 0) begin
            $display("** rgba_blend_mode_compositor: PASSED **");
        end else begin
            $display("** rgba_blend_mode_compositor: FAILED **");
        end
        $finish;
    end

endmodule
